### sv/cpd_pkg.sv
// cpd_pkg: shared types and constants of the CTAPHID payload deframer
// used by cpd_core, cpd_outq and ctaphid_payload_deframer_top
package cpd_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 64;
  localparam int unsigned MAX_PAYLOAD_DEF  = 7609;
  localparam int unsigned MAX_PACKETS_DEF  = 128;

  localparam int unsigned INIT_DATA_OFS = 7;
  localparam int unsigned CONT_SEQ_OFS  = 4;
  localparam int unsigned CONT_DATA_OFS = 5;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned COUNT_W = 8;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = 2;
  localparam int unsigned OQ_CNT_W = 3;

  typedef struct packed {
    logic [BYTE_W-1:0]  msg_byte;
    logic               first_of_message;
    logic [LEN_W-1:0]   payload_length;
    logic [COUNT_W-1:0] packet_count;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              is_status;
    logic              is_last;
    logic              status_error;
  } out_t;

  typedef struct packed {
    logic [1:0]      cnt;
    out_t [1:0]      res;
  } push_t;

endpackage

### sv/ctaphid_payload_deframer_top.sv
// CTAPHID payload deframer: takes one request byte per cycle while input ready is high
// and returns payload bytes followed by a final status result. Results are registered in
// a four-entry result queue before they reach the output; it parts the two sides:
// input ready is high while the queue has at least two free entries, so bytes stream
// at one per cycle while the output is taken; the byte that both carries payload and
// closes the message yields two results, which leave the queue one after the other.
// depends on cpd_pkg, cpd_core, cpd_outq
module ctaphid_payload_deframer_top import cpd_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int unsigned MAX_PACKETS  = MAX_PACKETS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  push_t push;
  logic  room;
  logic  accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  cpd_core #(
    .PACKET_BYTES(PACKET_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_PACKETS (MAX_PACKETS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (in_data_i),
    .push_o  (push)
  );

  cpd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### sv/cpd_core.sv
// cpd_core: per-byte deframing state and result generation
// depends on cpd_pkg
module cpd_core import cpd_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int unsigned MAX_PACKETS  = MAX_PACKETS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  in_t   req_i,
  output push_t push_o
);

  localparam int unsigned BW = $clog2(PACKET_BYTES);

  logic [BW-1:0]      bip_q, bip_d;
  logic [COUNT_W-1:0] pidx_q, pidx_d;
  logic [LEN_W-1:0]   left_q, left_d;
  logic [COUNT_W-1:0] exp_q, exp_d;
  logic               err_q, err_d;
  logic               act_q, act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bip_q  <= '0;
      pidx_q <= '0;
      left_q <= '0;
      exp_q  <= '0;
      err_q  <= 1'b0;
      act_q  <= 1'b0;
    end else begin
      bip_q  <= bip_d;
      pidx_q <= pidx_d;
      left_q <= left_d;
      exp_q  <= exp_d;
      err_q  <= err_d;
      act_q  <= act_d;
    end
  end

  always_comb begin
    logic               bad;
    logic               go;
    logic [BW-1:0]      bip;
    logic [COUNT_W-1:0] pidx;
    logic [LEN_W-1:0]   left;
    logic [COUNT_W-1:0] expc;
    logic               err;
    logic [BW-1:0]      data_from;
    logic               seq_err;
    logic               emit;
    logic               done;
    out_t               st;
    out_t               by;

    bip_d  = bip_q;
    pidx_d = pidx_q;
    left_d = left_q;
    exp_d  = exp_q;
    err_d  = err_q;
    act_d  = act_q;
    push_o = '0;

    bad = req_i.first_of_message &&
          (req_i.payload_length == '0 ||
           req_i.payload_length > LEN_W'(MAX_PAYLOAD) ||
           req_i.packet_count == '0 ||
           req_i.packet_count > COUNT_W'(MAX_PACKETS));
    go  = req_i.first_of_message ? !bad : act_q;

    bip  = req_i.first_of_message ? '0 : bip_q;
    pidx = req_i.first_of_message ? '0 : pidx_q;
    left = req_i.first_of_message ? req_i.payload_length : left_q;
    expc = req_i.first_of_message ? req_i.packet_count : exp_q;
    err  = req_i.first_of_message ? 1'b0 : err_q;

    data_from = (pidx == '0) ? BW'(INIT_DATA_OFS) : BW'(CONT_DATA_OFS);
    seq_err   = (pidx != '0) && (bip == BW'(CONT_SEQ_OFS)) &&
                (req_i.msg_byte != BYTE_W'(pidx - COUNT_W'(1)));
    emit      = (bip >= data_from) && (left != '0);
    done      = (bip == BW'(PACKET_BYTES - 1)) &&
                ({1'b0, pidx} + (COUNT_W+1)'(1) >= {1'b0, expc});

    by.payload_byte = req_i.msg_byte;
    by.is_status    = 1'b0;
    by.is_last      = 1'b0;
    by.status_error = 1'b0;

    st.payload_byte = '0;
    st.is_status    = 1'b1;
    st.is_last      = 1'b1;
    st.status_error = (err | seq_err) | ((left - LEN_W'(emit)) != '0);

    if (accept_i) begin
      if (bad) begin
        st.status_error = 1'b1;
        push_o.cnt      = 2'd1;
        push_o.res[0]   = st;
        bip_d  = '0;
        pidx_d = '0;
        left_d = '0;
        exp_d  = '0;
        err_d  = 1'b0;
        act_d  = 1'b0;
      end else if (go) begin
        if (emit) begin
          push_o.res[0] = by;
          push_o.res[1] = st;
        end else begin
          push_o.res[0] = st;
        end
        push_o.cnt = 2'(emit) + 2'(done);
        if (done) begin
          bip_d  = '0;
          pidx_d = '0;
          left_d = '0;
          exp_d  = '0;
          err_d  = 1'b0;
          act_d  = 1'b0;
        end else begin
          act_d  = 1'b1;
          exp_d  = expc;
          err_d  = err | seq_err;
          left_d = left - LEN_W'(emit);
          if (bip == BW'(PACKET_BYTES - 1)) begin
            bip_d  = '0;
            pidx_d = pidx + COUNT_W'(1);
          end else begin
            bip_d  = bip + BW'(1);
            pidx_d = pidx;
          end
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> !push_o.res[0].is_status && push_o.res[1].is_status)
    else $error("two results must be a byte then a status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((push_o.cnt == 2'd1 && push_o.res[0].is_status) ||
     (push_o.cnt == 2'd2 && push_o.res[1].is_status)) |=> !act_q)
    else $error("message still open after status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && act_q && !req_i.first_of_message && push_o.cnt == 2'd1 &&
     !push_o.res[0].is_status) |=> left_q == $past(left_q) - LEN_W'(1))
    else $error("byte count not decremented");

endmodule

### sv/cpd_outq.sv
// cpd_outq: four-entry result queue taking up to two results per cycle
// depends on cpd_pkg
module cpd_outq import cpd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  out_t                mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_q, wr_d;
  logic [OQ_PTR_W-1:0] rd_q, rd_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign room_o      = cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2);

  always_comb begin
    wr_d  = wr_q + OQ_PTR_W'(push_i.cnt);
    rd_d  = rd_q + OQ_PTR_W'(pop);
    cnt_d = cnt_q + OQ_CNT_W'(push_i.cnt) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + OQ_PTR_W'(1)] <= push_i.res[1];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> ({1'b0, cnt_q} + (OQ_CNT_W+1)'(push_i.cnt)) <=
                           (OQ_CNT_W+1)'(OQ_DEPTH))
    else $error("push without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    OQ_PTR_W'(wr_q - rd_q) == cnt_q[OQ_PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule
